// ===== rtl/cbsf_pkg.sv =====
package cbsf_pkg;

    localparam logic [7:0]  FLAG_BYTE = 8'h7E;
    localparam logic [7:0]  ESC_BYTE  = 8'h7D;
    localparam logic [7:0]  ESC_XOR   = 8'h20;
    localparam logic [15:0] CRC_POLY  = 16'h1021;

    // One accepted message byte, classified and with its CRC already folded in
    typedef struct packed {
        logic        open_flag;
        logic [7:0]  data;
        logic        last;
        logic [15:0] crc;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } push_t;

    typedef enum logic [2:0] {
        STEP_OPEN,
        STEP_DATA,
        STEP_CRC_LO,
        STEP_CRC_HI,
        STEP_CLOSE
    } step_t;

    // Table form: T[crc >> 8] ^ (crc << 8) ^ byte; T is built bitwise here
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        r = {crc[15:8], 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (r[15])
            begin
                r = {r[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                r = {r[14:0], 1'b0};
            end
        end
        return r ^ {crc[7:0], 8'h00} ^ {8'h00, b};
    endfunction

endpackage

// ===== rtl/cbsf_in_if.sv =====
interface cbsf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] message_byte;
    logic       is_last;

    modport source (output valid, output message_byte, output is_last, input ready);
    modport sink (input valid, input message_byte, input is_last, output ready);
endinterface

// ===== rtl/cbsf_out_if.sv =====
interface cbsf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;

    modport source (output valid, output out_byte, output run_last, input ready);
    modport sink (input valid, input out_byte, input run_last, output ready);
endinterface

// ===== rtl/cbsf_front.sv =====
module cbsf_front (
    input  logic             clk,
    input  logic             rst_n,
    cbsf_in_if.sink          msg,
    input  logic             full,
    output cbsf_pkg::push_t  push
);

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic        inside_reg;
    logic        inside_next;
    logic [15:0] crc_base;
    logic [15:0] crc_new;
    logic        accept;

    assign msg.ready = !full;

    always_comb
    begin
        accept   = msg.valid && !full;
        // restart the CRC when this byte opens a frame
        crc_base = inside_reg ? crc_reg : 16'h0000;
        crc_new  = cbsf_pkg::crc_update(crc_base, msg.message_byte);

        push.valid         = accept;
        push.job.open_flag = !inside_reg;
        push.job.data      = msg.message_byte;
        push.job.last      = msg.is_last;
        push.job.crc       = crc_new;

        crc_next    = crc_reg;
        inside_next = inside_reg;
        if (accept)
        begin
            crc_next    = msg.is_last ? 16'h0000 : crc_new;
            inside_next = !msg.is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg    <= 16'h0000;
            inside_reg <= 1'b0;
        end
        else
        begin
            crc_reg    <= crc_next;
            inside_reg <= inside_next;
        end
    end

endmodule

// ===== rtl/cbsf_queue.sv =====
module cbsf_queue #(
    parameter int DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  cbsf_pkg::push_t push,
    input  logic            pop,
    output logic            full,
    output logic            not_empty,
    output cbsf_pkg::job_t  head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cbsf_pkg::job_t  mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push.valid && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push.valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem_reg[wr_ptr_reg] <= push.job;
        end
    end

endmodule

// ===== rtl/cbsf_back.sv =====
module cbsf_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            not_empty,
    input  cbsf_pkg::job_t  head,
    output logic            pop,
    cbsf_out_if.source      frame
);

    cbsf_pkg::step_t step_reg;
    cbsf_pkg::step_t step_next;
    cbsf_pkg::step_t cur_step;
    cbsf_pkg::step_t adv_step;
    logic            started_reg;
    logic            started_next;
    logic            esc_reg;
    logic            esc_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic [7:0]      out_byte_reg;
    logic [7:0]      out_byte_next;
    logic            run_last_reg;
    logic            run_last_next;
    logic [7:0]      raw;
    logic            stuffable;
    logic            done;
    logic            emit;

    assign frame.valid    = out_valid_reg;
    assign frame.out_byte = out_byte_reg;
    assign frame.run_last = run_last_reg;

    always_comb
    begin
        // a fresh request at the queue head starts at its flag or its data
        if (started_reg)
        begin
            cur_step = step_reg;
        end
        else
        begin
            cur_step = head.open_flag ? cbsf_pkg::STEP_OPEN : cbsf_pkg::STEP_DATA;
        end

        raw       = cbsf_pkg::FLAG_BYTE;
        stuffable = 1'b0;
        done      = 1'b0;
        adv_step  = cur_step;
        case (cur_step)
            cbsf_pkg::STEP_OPEN:
            begin
                raw      = cbsf_pkg::FLAG_BYTE;
                adv_step = cbsf_pkg::STEP_DATA;
            end
            cbsf_pkg::STEP_DATA:
            begin
                raw       = head.data;
                stuffable = 1'b1;
                done      = !head.last;
                adv_step  = cbsf_pkg::STEP_CRC_LO;
            end
            cbsf_pkg::STEP_CRC_LO:
            begin
                raw       = head.crc[7:0];
                stuffable = 1'b1;
                adv_step  = cbsf_pkg::STEP_CRC_HI;
            end
            cbsf_pkg::STEP_CRC_HI:
            begin
                raw       = head.crc[15:8];
                stuffable = 1'b1;
                adv_step  = cbsf_pkg::STEP_CLOSE;
            end
            cbsf_pkg::STEP_CLOSE:
            begin
                raw  = cbsf_pkg::FLAG_BYTE;
                done = 1'b1;
            end
            default:
            begin
                raw  = cbsf_pkg::FLAG_BYTE;
                done = 1'b1;
            end
        endcase
        stuffable = stuffable && (raw == cbsf_pkg::ESC_BYTE || raw == cbsf_pkg::FLAG_BYTE);

        emit = not_empty && (!out_valid_reg || frame.ready);

        step_next      = step_reg;
        started_next   = started_reg;
        esc_next       = esc_reg;
        out_byte_next  = out_byte_reg;
        run_last_next  = run_last_reg;
        out_valid_next = frame.ready ? 1'b0 : out_valid_reg;
        pop            = 1'b0;

        if (emit)
        begin
            out_valid_next = 1'b1;
            if (stuffable && !esc_reg)
            begin
                // send the escape code, hold the step for the flipped byte
                out_byte_next = cbsf_pkg::ESC_BYTE;
                run_last_next = 1'b0;
                esc_next      = 1'b1;
                started_next  = 1'b1;
                step_next     = cur_step;
            end
            else
            begin
                out_byte_next = esc_reg ? (raw ^ cbsf_pkg::ESC_XOR) : raw;
                run_last_next = done;
                esc_next      = 1'b0;
                step_next     = adv_step;
                started_next  = !done;
                pop           = done;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= cbsf_pkg::STEP_OPEN;
            started_reg   <= 1'b0;
            esc_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            started_reg   <= started_next;
            esc_reg       <= esc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        run_last_reg <= run_last_next;
    end

endmodule

// ===== rtl/crc16_byte_stuffing_framer.sv =====
// Channel  Role   Payload                  Handshake
// msg      sink   message_byte, is_last    valid / ready
// frame    source out_byte, run_last       valid / ready
//
// Each message byte becomes 1 to 8 framed bytes; the back end sends one byte
// per cycle while frame is not stalled, so a request holds the queue head until all its bytes are sent.
// The front end computes the CRC in the accept cycle and takes a new request
// every cycle while the queue of QUEUE_DEPTH entries has room.
// Reset is asynchronous and active low; it drops any open frame without a closing flag.
// A stall on frame holds the output register and fills the queue, then drops msg.ready.
module crc16_byte_stuffing_framer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    cbsf_in_if.sink    msg,
    cbsf_out_if.source frame
);

    cbsf_pkg::push_t push;
    cbsf_pkg::job_t  head;
    logic            full;
    logic            not_empty;
    logic            pop;

    cbsf_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg),
        .full  (full),
        .push  (push)
    );

    cbsf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (pop),
        .full      (full),
        .not_empty (not_empty),
        .head      (head)
    );

    cbsf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (not_empty),
        .head      (head),
        .pop       (pop),
        .frame     (frame)
    );

endmodule

// ===== rtl/cbsf_checker.sv =====
module cbsf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       msg_valid,
    input logic       msg_ready,
    input logic       frame_valid,
    input logic       frame_ready,
    input logic [7:0] out_byte,
    input logic       run_last
);

    logic after_esc_reg;
    logic after_esc_next;
    logic frame_accept;

    assign frame_accept   = frame_valid && frame_ready;
    assign after_esc_next = frame_accept ? (out_byte == cbsf_pkg::ESC_BYTE && !after_esc_reg)
                                         : after_esc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            after_esc_reg <= 1'b0;
        end
        else
        begin
            after_esc_reg <= after_esc_next;
        end
    end

    a_frame_hold: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && !frame_ready |=> frame_valid && $stable(out_byte) && $stable(run_last))
        else $error("framed byte changed while stalled");

    a_esc_follow: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && after_esc_reg |->
            out_byte == (cbsf_pkg::ESC_BYTE ^ cbsf_pkg::ESC_XOR) ||
            out_byte == (cbsf_pkg::FLAG_BYTE ^ cbsf_pkg::ESC_XOR))
        else $error("escape code not followed by a flipped flag or escape");

    a_esc_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && !after_esc_reg && out_byte == cbsf_pkg::ESC_BYTE |-> !run_last)
        else $error("escape code marked as last byte of a request");

    a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !frame_valid)
        else $error("output valid right after reset");

    a_msg_hold: assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && !msg_ready |=> msg_valid)
        else $error("message request dropped before it was taken");

endmodule

bind crc16_byte_stuffing_framer cbsf_checker u_cbsf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .msg_valid   (msg.valid),
    .msg_ready   (msg.ready),
    .frame_valid (frame.valid),
    .frame_ready (frame.ready),
    .out_byte    (frame.out_byte),
    .run_last    (frame.run_last)
);

// ===== tb/crc16_byte_stuffing_framer_checker.sv =====
`timescale 1ns / 100ps

module crc16_byte_stuffing_framer_checker (
    input  logic clk,
    input  logic rst_n,
    cbsf_in_if   msg,
    cbsf_out_if  frame,
    output int   mismatch_count,
    output int   pending_count
);

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } framed_byte_t;

    framed_byte_t framed_q[$];
    logic [15:0]  crc_acc;
    logic         frame_open;
    logic [15:0]  crc_tab [256];

    // Remainder of each high byte pushed through eight zero bits
    initial
    begin
        logic [15:0] r;
        for (int v = 0; v < 256; v++)
        begin
            r = {v[7:0], 8'h00};
            for (int k = 0; k < 8; k++)
            begin
                r = r[15] ? ({r[14:0], 1'b0} ^ cbsf_pkg::CRC_POLY) : {r[14:0], 1'b0};
            end
            crc_tab[v] = r;
        end
    end

    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        return crc_tab[crc[15:8]] ^ {crc[7:0], 8'h00} ^ {8'h00, b};
    endfunction

    task automatic emit_byte(input logic [7:0] b);
        framed_byte_t fb;
        fb.out_byte = b;
        fb.run_last = 1'b0;
        framed_q.insert(framed_q.size(), fb);
    endtask

    task automatic emit_stuffed(input logic [7:0] b);
        if (b == cbsf_pkg::ESC_BYTE || b == cbsf_pkg::FLAG_BYTE)
        begin
            emit_byte(cbsf_pkg::ESC_BYTE);
            emit_byte(b ^ cbsf_pkg::ESC_XOR);
        end
        else
        begin
            emit_byte(b);
        end
    endtask

    task automatic predict_framing(input logic [7:0] b, input logic last);
        framed_byte_t tail;
        if (!frame_open)
        begin
            emit_byte(cbsf_pkg::FLAG_BYTE);
            crc_acc = 16'h0000;
            frame_open = 1'b1;
        end
        crc_acc = crc_fold(crc_acc, b);
        emit_stuffed(b);
        if (last)
        begin
            emit_stuffed(crc_acc[7:0]);
            emit_stuffed(crc_acc[15:8]);
            emit_byte(cbsf_pkg::FLAG_BYTE);
            crc_acc = 16'h0000;
            frame_open = 1'b0;
        end
        // mark the final byte of this request
        tail = framed_q.pop_back();
        tail.run_last = 1'b1;
        framed_q.insert(framed_q.size(), tail);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        framed_byte_t want;
        if (!rst_n)
        begin
            framed_q.delete();
            crc_acc = 16'h0000;
            frame_open = 1'b0;
            mismatch_count = 0;
            pending_count <= 0;
        end
        else
        begin
            if (msg.valid && msg.ready)
            begin
                predict_framing(msg.message_byte, msg.is_last);
            end
            if (frame.valid && frame.ready)
            begin
                if (framed_q.size() == 0)
                begin
                    $error("frame: unexpected byte, out_byte %h run_last %b",
                           frame.out_byte, frame.run_last);
                    mismatch_count++;
                end
                else
                begin
                    want = framed_q.pop_front();
                    if (frame.out_byte !== want.out_byte)
                    begin
                        $error("out_byte: expected %h, got %h", want.out_byte, frame.out_byte);
                        mismatch_count++;
                    end
                    if (frame.run_last !== want.run_last)
                    begin
                        $error("run_last: expected %b, got %b", want.run_last, frame.run_last);
                        mismatch_count++;
                    end
                end
            end
            pending_count <= framed_q.size();
        end
    end

endmodule

// ===== tb/crc16_byte_stuffing_framer_tb.sv =====
`timescale 1ns / 100ps

module crc16_byte_stuffing_framer_tb;

    localparam int QUIET_LIMIT  = 4000;
    localparam int ITEMS_PER_PH = 35;

    logic clk;
    logic rst_n;
    int   idle_pct;
    int   stall_pct;
    int   quiet_cycles;
    int   mismatches;
    int   pending;

    cbsf_in_if  msg_if ();
    cbsf_out_if frame_if ();

    crc16_byte_stuffing_framer u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .msg   (msg_if),
        .frame (frame_if)
    );

    crc16_byte_stuffing_framer_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .msg            (msg_if),
        .frame          (frame_if),
        .mismatch_count (mismatches),
        .pending_count  (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        msg_if.valid = 1'b0;
        msg_if.message_byte = 8'h00;
        msg_if.is_last = 1'b0;
        frame_if.ready = 1'b0;
    end

    always @(posedge clk)
    begin
        frame_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if ((msg_if.valid && msg_if.ready) || (frame_if.valid && frame_if.ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        @(posedge clk);
        while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
        $display("CHECK FAILED");
        $finish;
    end

    // Hold valid and payload until the request is taken
    task automatic send_byte(input logic [7:0] b, input logic last);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            msg_if.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < idle_pct) @(posedge clk);
        end
        msg_if.valid <= 1'b1;
        msg_if.message_byte <= b;
        msg_if.is_last <= last;
        @(posedge clk);
        while (!msg_if.ready) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h7E;
            1:       return 8'h7D;
            2:       return ($urandom_range(0, 1) != 0) ? 8'h5E : 8'h5D;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_random_phase(input int idle, input int stall);
        int sent;
        int len;
        idle_pct = idle;
        stall_pct = stall;
        sent = 0;
        while (sent < ITEMS_PER_PH)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
            begin
                send_byte(pick_byte(), i == len - 1);
            end
            sent += len;
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-byte frames; the CRC equals the byte itself
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h7E, 1'b1);
        send_byte(8'h7D, 1'b1);
        // two-byte frames: CRC is {first, second}, escape one or both CRC bytes; then longer frames
        send_byte(8'h7E, 1'b0);
        send_byte(8'h7D, 1'b1);
        send_byte(8'h7D, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7E, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h7E, 1'b1);

        send_random_phase(0, 0);
        send_random_phase(84, 0);
        send_random_phase(0, 84);
        send_random_phase(6, 6);

        msg_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/cbsf_pkg.sv
rtl/cbsf_in_if.sv
rtl/cbsf_out_if.sv
rtl/cbsf_front.sv
rtl/cbsf_queue.sv
rtl/cbsf_back.sv
rtl/crc16_byte_stuffing_framer.sv
rtl/cbsf_checker.sv
tb/crc16_byte_stuffing_framer_checker.sv
tb/crc16_byte_stuffing_framer_tb.sv
